[rtl/hsv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types, constants and helper functions for the HSV to RGB pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int unsigned ChanW       = 8;
  localparam int unsigned RegionWidth = 43;
  localparam int unsigned OffsetScale = 6;
  localparam int unsigned Full        = 255;
  localparam int unsigned RoundHalf   = 127;
  localparam int unsigned TermShift   = 8;

  typedef logic [ChanW-1:0]   chan_t;
  typedef logic [2*ChanW-1:0] prod_t;

  // Pixel handling mode, picked from saturation
  typedef enum logic [1:0] {
    MODE_GRAY  = 2'd0,
    MODE_FULL  = 2'd1,
    MODE_SHADE = 2'd2
  } pix_mode_e;

  // Six hue regions of the color wheel
  typedef enum logic [2:0] {
    RGN_0 = 3'd0,
    RGN_1 = 3'd1,
    RGN_2 = 3'd2,
    RGN_3 = 3'd3,
    RGN_4 = 3'd4,
    RGN_5 = 3'd5
  } region_e;

  // Beat handed from the shading stages to the scaling stages
  typedef struct packed {
    region_e   region;
    pix_mode_e mode;
    chan_t     v;
    chan_t     p;
    chan_t     q;
    chan_t     t;
  } shade_t;

  function automatic region_e hue_region(input chan_t h);
    region_e r;
    if (h < chan_t'(RegionWidth)) begin
      r = RGN_0;
    end else if (h < chan_t'(2 * RegionWidth)) begin
      r = RGN_1;
    end else if (h < chan_t'(3 * RegionWidth)) begin
      r = RGN_2;
    end else if (h < chan_t'(4 * RegionWidth)) begin
      r = RGN_3;
    end else if (h < chan_t'(5 * RegionWidth)) begin
      r = RGN_4;
    end else begin
      r = RGN_5;
    end
    return r;
  endfunction

  // Offset within the region, scaled by six (at most 252)
  function automatic chan_t hue_frac(input chan_t h, input region_e r);
    chan_t base;
    chan_t rem;
    unique case (r)
      RGN_0:   base = chan_t'(0);
      RGN_1:   base = chan_t'(RegionWidth);
      RGN_2:   base = chan_t'(2 * RegionWidth);
      RGN_3:   base = chan_t'(3 * RegionWidth);
      RGN_4:   base = chan_t'(4 * RegionWidth);
      RGN_5:   base = chan_t'(5 * RegionWidth);
      default: base = chan_t'(0);
    endcase
    rem = h - base;
    return chan_t'(rem * chan_t'(OffsetScale));
  endfunction

  // floor(x / 255) for x below 65280
  function automatic chan_t div255(input prod_t x);
    logic [2*ChanW:0] sum;
    sum = {1'b0, x} + {{(ChanW+1){1'b0}}, x[2*ChanW-1:ChanW]} + {{(2*ChanW){1'b0}}, 1'b1};
    return sum[2*ChanW-1:ChanW];
  endfunction

endpackage

[rtl/hsv2rgb_shade.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_shade
// Three-stage front end: hue split, shading products, p/q/t terms.
// ----------------------------------------------------------------------------
module hsv2rgb_shade (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hsv2rgb_pkg::chan_t  hue_i,
  input  hsv2rgb_pkg::chan_t  saturation_i,
  input  hsv2rgb_pkg::chan_t  brightness_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hsv2rgb_pkg::shade_t out_data_o
);
  import hsv2rgb_pkg::*;

  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_en, s2_en, s3_en;

  // stage 1 registers
  region_e   s1_region_q;
  pix_mode_e s1_mode_q;
  chan_t     s1_frac_q, s1_s_q, s1_veff_q, s1_v_q;
  // stage 2 registers
  region_e   s2_region_q;
  pix_mode_e s2_mode_q;
  chan_t     s2_a_q, s2_b_q, s2_p_q, s2_veff_q, s2_v_q;
  // stage 3 register
  shade_t    s3_q;

  pix_mode_e mode_d;
  chan_t     s_d, veff_d;
  prod_t     sf_d, sg_d, pv_d, qv_d, tv_d;
  shade_t    s3_d;

  assign s3_en      = !s3_valid_q || out_ready_i;
  assign s2_en      = !s2_valid_q || s3_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  always_comb begin
    if (saturation_i == '0) begin
      mode_d = MODE_GRAY;
    end else if (saturation_i == chan_t'(Full)) begin
      mode_d = MODE_FULL;
    end else begin
      mode_d = MODE_SHADE;
    end
    // full saturation shades a base color at s = v = 255
    s_d    = (mode_d == MODE_FULL) ? chan_t'(Full) : saturation_i;
    veff_d = (mode_d == MODE_FULL) ? chan_t'(Full) : brightness_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_region_q <= hue_region(hue_i);
      s1_frac_q   <= hue_frac(hue_i, hue_region(hue_i));
      s1_mode_q   <= mode_d;
      s1_s_q      <= s_d;
      s1_veff_q   <= veff_d;
      s1_v_q      <= brightness_i;
    end
  end

  always_comb begin
    sf_d = prod_t'(s1_s_q) * prod_t'(s1_frac_q);
    sg_d = prod_t'(s1_s_q) * prod_t'(chan_t'(Full) - s1_frac_q);
    pv_d = prod_t'(s1_veff_q) * prod_t'(chan_t'(Full) - s1_s_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      s2_a_q      <= sf_d[TermShift +: ChanW];
      s2_b_q      <= sg_d[TermShift +: ChanW];
      s2_p_q      <= pv_d[TermShift +: ChanW];
      s2_region_q <= s1_region_q;
      s2_mode_q   <= s1_mode_q;
      s2_veff_q   <= s1_veff_q;
      s2_v_q      <= s1_v_q;
    end
  end

  always_comb begin
    qv_d        = prod_t'(s2_veff_q) * prod_t'(chan_t'(Full) - s2_a_q);
    tv_d        = prod_t'(s2_veff_q) * prod_t'(chan_t'(Full) - s2_b_q);
    s3_d.region = s2_region_q;
    s3_d.mode   = s2_mode_q;
    s3_d.v      = s2_v_q;
    s3_d.p      = s2_p_q;
    s3_d.q      = qv_d[TermShift +: ChanW];
    s3_d.t      = tv_d[TermShift +: ChanW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en && s2_valid_q) begin
      s3_q <= s3_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_data_o  = s3_q;

endmodule

[rtl/hsv2rgb_scale.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// Two-stage back end: region mux with brightness product, then /255.
// ----------------------------------------------------------------------------
module hsv2rgb_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hsv2rgb_pkg::shade_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hsv2rgb_pkg::chan_t  red_o,
  output hsv2rgb_pkg::chan_t  green_o,
  output hsv2rgb_pkg::chan_t  blue_o
);
  import hsv2rgb_pkg::*;

  logic      s4_valid_q, s5_valid_q;
  logic      s4_en, s5_en;
  pix_mode_e s4_mode_q;
  prod_t     s4_r_q, s4_g_q, s4_b_q;
  chan_t     s5_r_q, s5_g_q, s5_b_q;

  chan_t     vsel, base_r, base_g, base_b;
  prod_t     r_d, g_d, b_d;

  assign s5_en      = !s5_valid_q || out_ready_i;
  assign s4_en      = !s4_valid_q || s5_en;
  assign in_ready_o = s4_en;

  always_comb begin
    vsel = (in_data_i.mode == MODE_FULL) ? chan_t'(Full) : in_data_i.v;
    case (in_data_i.region)
      RGN_0:   begin base_r = vsel;        base_g = in_data_i.t; base_b = in_data_i.p; end
      RGN_1:   begin base_r = in_data_i.q; base_g = vsel;        base_b = in_data_i.p; end
      RGN_2:   begin base_r = in_data_i.p; base_g = vsel;        base_b = in_data_i.t; end
      RGN_3:   begin base_r = in_data_i.p; base_g = in_data_i.q; base_b = vsel;        end
      RGN_4:   begin base_r = in_data_i.t; base_g = in_data_i.p; base_b = vsel;        end
      default: begin base_r = vsel;        base_g = in_data_i.p; base_b = in_data_i.q; end
    endcase

    unique case (in_data_i.mode)
      MODE_GRAY: begin
        r_d = prod_t'(in_data_i.v);
        g_d = prod_t'(in_data_i.v);
        b_d = prod_t'(in_data_i.v);
      end
      MODE_FULL: begin
        r_d = prod_t'(base_r) * prod_t'(in_data_i.v) + prod_t'(RoundHalf);
        g_d = prod_t'(base_g) * prod_t'(in_data_i.v) + prod_t'(RoundHalf);
        b_d = prod_t'(base_b) * prod_t'(in_data_i.v) + prod_t'(RoundHalf);
      end
      default: begin
        r_d = prod_t'(base_r);
        g_d = prod_t'(base_g);
        b_d = prod_t'(base_b);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (s4_en) begin
      s4_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_en && in_valid_i) begin
      s4_mode_q <= in_data_i.mode;
      s4_r_q    <= r_d;
      s4_g_q    <= g_d;
      s4_b_q    <= b_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (s5_en) begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s5_en && s4_valid_q) begin
      if (s4_mode_q == MODE_FULL) begin
        s5_r_q <= div255(s4_r_q);
        s5_g_q <= div255(s4_g_q);
        s5_b_q <= div255(s4_b_q);
      end else begin
        s5_r_q <= s4_r_q[ChanW-1:0];
        s5_g_q <= s4_g_q[ChanW-1:0];
        s5_b_q <= s4_b_q[ChanW-1:0];
      end
    end
  end

  assign out_valid_o = s5_valid_q;
  assign red_o       = s5_r_q;
  assign green_o     = s5_g_q;
  assign blue_o      = s5_b_q;

endmodule

[rtl/hsv_to_rgb_8bit_core.sv]
// Throughput: one pixel per cycle while the output is not stalled; every one of the
//   five stages holds its own beat.
// Backpressure: each stage loads whenever it is empty or its successor moves, so
//   bubbles are squeezed out and input is taken while a result waits at the output.
// Reset: rst_ni (async, active low) clears all stage valid bits; data regs are not reset.
// ----------------------------------------------------------------------------
// hsv_to_rgb_8bit_core
// 8-bit HSV to RGB converter, six hue regions, fully pipelined.
// ----------------------------------------------------------------------------
module hsv_to_rgb_8bit_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hsv2rgb_pkg::chan_t hue_i,
  input  hsv2rgb_pkg::chan_t saturation_i,
  input  hsv2rgb_pkg::chan_t brightness_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hsv2rgb_pkg::chan_t red_o,
  output hsv2rgb_pkg::chan_t green_o,
  output hsv2rgb_pkg::chan_t blue_o
);
  import hsv2rgb_pkg::*;

  // Stages 1-3: region/offset split, s*frac products, then p/q/t terms.
  // Gray and full-saturation beats carry their mode along; full saturation
  // shades a base color at s = v = 255 so the same datapath serves both.
  logic   mid_valid, mid_ready;
  shade_t mid_data;

  hsv2rgb_shade u_shade (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_o  (mid_valid),
    .out_ready_i  (mid_ready),
    .out_data_o   (mid_data)
  );

  // Stages 4-5: region mux routes p/q/t to channels; on full saturation each
  // base channel is scaled by brightness with round-half, then divided by 255
  // with a shift-add trick (exact for all reachable sums).
  hsv2rgb_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_data_i   (mid_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

endmodule

[rtl/hsv2rgb_chk.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_chk
// Port-level checks for the HSV to RGB core, bound to the top level.
// ----------------------------------------------------------------------------
module hsv2rgb_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input hsv2rgb_pkg::chan_t red_o,
  input hsv2rgb_pkg::chan_t green_o,
  input hsv2rgb_pkg::chan_t blue_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned Depth = 5;

  logic [2:0] inflight_q, inflight_d;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_beat && !out_beat) begin
      inflight_d = inflight_q + 3'd1;
    end else if (!in_beat && out_beat) begin
      inflight_d = inflight_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("output payload changed while stalled");

  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'(Depth))
    else $error("more beats in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 3'd0)
    else $error("output beat without a matching input beat");

endmodule

bind hsv_to_rgb_8bit_core hsv2rgb_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .red_o       (red_o),
  .green_o     (green_o),
  .blue_o      (blue_o)
);

[bench/hsv_to_rgb_8bit_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_8bit_core_tb
// Self-checking bench for the HSV to RGB core. A directed set covers the hue
// region edges, gray, full and near-full saturation. A random set then mixes
// all three modes while both sides insert random idle cycles. Every accepted
// output beat is checked field by field against an in-bench color model.
// ----------------------------------------------------------------------------
module hsv_to_rgb_8bit_core_tb;
  import hsv2rgb_pkg::*;

  // Color math constants
  localparam int unsigned HueSpan   = 43;   // hues per region
  localparam int unsigned FracScale = 6;    // region offset scale
  localparam int unsigned ChanMax   = 255;
  localparam int unsigned RoundBias = 127;
  localparam int unsigned ShadeSh   = 8;

  // Run shape
  localparam int unsigned MaxGap       = 18;
  localparam int unsigned RandomPixels = 650;
  localparam int unsigned DrainCycles  = 20;   // pipeline is 5 deep, leave margin
  localparam int unsigned MaxPrinted   = 60;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the color of each accepted input beat and matches
  // output beats against the oldest prediction.
  // --------------------------------------------------------------------------
  class rgb_scoreboard;
    rgb_t        pending_rgb[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned printed;

    function new();
      mismatches = 0;
      checked    = 0;
      printed    = 0;
    endfunction

    static function pix_mode_e mode_of(int unsigned s);
      if (s == 0) return MODE_GRAY;
      if (s == ChanMax) return MODE_FULL;
      return MODE_SHADE;
    endfunction

    // Six-region shading with truncating shifts
    function void shade(int unsigned h, int unsigned s, int unsigned v, output rgb_t c);
      region_e     rgn;
      int unsigned frac;
      int unsigned p;
      int unsigned q;
      int unsigned t;
      rgn  = region_e'(h / HueSpan);
      frac = (h - (h / HueSpan) * HueSpan) * FracScale;
      p    = (v * (ChanMax - s)) >> ShadeSh;
      q    = (v * (ChanMax - ((s * frac) >> ShadeSh))) >> ShadeSh;
      t    = (v * (ChanMax - ((s * (ChanMax - frac)) >> ShadeSh))) >> ShadeSh;
      case (rgn)
        RGN_0:   c = '{chan_t'(v), chan_t'(t), chan_t'(p)};
        RGN_1:   c = '{chan_t'(q), chan_t'(v), chan_t'(p)};
        RGN_2:   c = '{chan_t'(p), chan_t'(v), chan_t'(t)};
        RGN_3:   c = '{chan_t'(p), chan_t'(q), chan_t'(v)};
        RGN_4:   c = '{chan_t'(t), chan_t'(p), chan_t'(v)};
        default: c = '{chan_t'(v), chan_t'(p), chan_t'(q)};
      endcase
    endfunction

    // Rounded brightness scaling of a full-saturation base channel
    static function chan_t scale_full(int unsigned base, int unsigned v);
      return chan_t'((base * v + RoundBias) / ChanMax);
    endfunction

    function rgb_t convert_pixel(chan_t h, chan_t s, chan_t v);
      rgb_t c;
      rgb_t base;
      case (mode_of(s))
        MODE_GRAY: c = '{v, v, v};
        MODE_FULL: begin
          shade(h, ChanMax, ChanMax, base);
          c.red   = scale_full(base.red, v);
          c.green = scale_full(base.green, v);
          c.blue  = scale_full(base.blue, v);
        end
        default:   shade(h, s, v, c);
      endcase
      return c;
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      mismatches++;
      if (printed < MaxPrinted) begin
        printed++;
        $display("%0t MISMATCH %s: got %0d, expected %0d (beat %0d)",
                 $realtime, what, got, want, checked);
      end
    endtask

    function void note_pixel(chan_t h, chan_t s, chan_t v);
      pending_rgb.push_back(convert_pixel(h, s, v));
    endfunction

    task check_pixel(rgb_t got);
      rgb_t want;
      if (pending_rgb.size() == 0) begin
        report("output beat with nothing pending, rgb", got, 0);
        return;
      end
      want = pending_rgb.pop_front();
      if (got.red != want.red) report("red", got.red, want.red);
      if (got.green != want.green) report("green", got.green, want.green);
      if (got.blue != want.blue) report("blue", got.blue, want.blue);
      checked++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  chan_t hue;
  chan_t sat;
  chan_t bri;
  logic  out_valid;
  logic  out_ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  hsv_to_rgb_8bit_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .hue_i        (hue),
    .saturation_i (sat),
    .brightness_i (bri),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .red_o        (red),
    .green_o      (green),
    .blue_o       (blue)
  );

  rgb_scoreboard sb = new();

  // Per-side state for no-idle stretches
  int unsigned send_quiet = 0;
  int unsigned recv_quiet = 0;
  int unsigned mode_count[3] = '{0, 0, 0};

  // Hue values on both sides of every region edge, plus the ends of the wheel
  chan_t hue_edges[12] = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd128,
                           8'd129, 8'd171, 8'd172, 8'd214, 8'd215, 8'd255};

  initial begin : clock_gen
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle cycles before the next beat: mostly uniform over 0..MaxGap, with
  // occasional back-to-back stretches so the pipeline runs full.
  function automatic int unsigned pick_gap(inout int unsigned quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MaxGap);
  endfunction

  // Extremes come up often, everything else uniform
  function automatic chan_t pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic chan_t pick_saturation();
    case ($urandom_range(0, 9))
      0, 1:    return 8'd0;
      2, 3:    return 8'd255;
      4:       return ($urandom_range(0, 1) != 0) ? 8'd1 : 8'd254;
      default: return chan_t'($urandom_range(1, 254));
    endcase
  endfunction

  function automatic chan_t pick_hue();
    if ($urandom_range(0, 5) == 0) return hue_edges[$urandom_range(0, 11)];
    return chan_t'($urandom_range(0, 255));
  endfunction

  // Input beat driver: called at a falling edge, returns at a falling edge.
  // With no gap the valid stays high and only the payload moves on.
  task automatic send_pixel(input chan_t h, input chan_t s, input chan_t v);
    int unsigned gap;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    hue      <= h;
    sat      <= s;
    bri      <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(h, s, v);
    mode_count[rgb_scoreboard::mode_of(s)]++;
    @(negedge clk);
  endtask

  // Output side: random ready stalls, every accepted beat goes to the scoreboard
  initial begin : sink
    int unsigned gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = pick_gap(recv_quiet);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_pixel('{red, green, blue});
      @(negedge clk);
    end
  end

  initial begin : stimulus
    rst_n    = 1'b0;
    in_valid = 1'b0;
    hue      = '0;
    sat      = '0;
    bri      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every region edge at full saturation and brightness
    foreach (hue_edges[i]) send_pixel(hue_edges[i], 8'd255, 8'd255);
    // Gray pixels, black and white included
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd100, 8'd0, 8'd170);
    // Saturation just off the gray and full paths
    send_pixel(8'd20, 8'd1, 8'd255);
    send_pixel(8'd200, 8'd254, 8'd255);
    // Full saturation with dark and mid brightness (rounding)
    send_pixel(8'd60, 8'd255, 8'd0);
    send_pixel(8'd130, 8'd255, 8'd128);
    send_pixel(8'd255, 8'd255, 8'd1);
    // Shading path across the first and last region edges, last region at its top offset
    send_pixel(8'd42, 8'd128, 8'd255);
    send_pixel(8'd43, 8'd128, 8'd255);
    send_pixel(8'd214, 8'd128, 8'd255);
    send_pixel(8'd215, 8'd128, 8'd255);
    send_pixel(8'd255, 8'd128, 8'd255);

    // Random mix of all three modes
    repeat (RandomPixels) send_pixel(pick_hue(), pick_saturation(), pick_level());
    in_valid <= 1'b0;

    // Drain the pipeline, then watch a little longer for stray beats
    while (sb.pending_rgb.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d pixels: %0d gray, %0d full saturation, %0d shaded.",
             mode_count[MODE_GRAY] + mode_count[MODE_FULL] + mode_count[MODE_SHADE],
             mode_count[MODE_GRAY], mode_count[MODE_FULL], mode_count[MODE_SHADE]);
    $display("Checked %0d output beats, %0d field mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("hsv_to_rgb_8bit_core test passed");
    end else begin
      $display("hsv_to_rgb_8bit_core test failed");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("Timeout waiting on handshakes");
    $display("hsv_to_rgb_8bit_core test failed");
    $finish;
  end

endmodule
